// ----- hdl/beu_pkg.sv -----
// ----------------------------------------------------------------------------
// beu_pkg
// Shared types and constants of the bytecode execute unit: opcodes, the
// instruction pointer register index and the control groups between modules.
// ----------------------------------------------------------------------------
package beu_pkg;

	// Opcodes of the command field.
	localparam logic [3:0] OP_MOV  = 4'd0;
	localparam logic [3:0] OP_SL   = 4'd1;
	localparam logic [3:0] OP_SR   = 4'd2;
	localparam logic [3:0] OP_LDR  = 4'd3;
	localparam logic [3:0] OP_STR  = 4'd4;
	localparam logic [3:0] OP_ADD  = 4'd5;
	localparam logic [3:0] OP_SUB  = 4'd6;
	localparam logic [3:0] OP_JZ   = 4'd7;
	localparam logic [3:0] OP_DOWN = 4'd8;

	// Register that serves as the instruction pointer, and its step.
	localparam logic [4:0]  IP_INDEX    = 5'd31;
	localparam logic [63:0] INSTR_BYTES = 64'd8;

	// Register file port control.
	typedef struct packed {
		logic rd;
		logic wr;
	} rf_ctl_t;

	// Data memory port control.
	typedef struct packed {
		logic rd;
		logic wr;
	} dm_ctl_t;

endpackage

// ----- hdl/beu_if.sv -----
// ----------------------------------------------------------------------------
// beu_if
// Valid/ready channels of the bytecode execute unit: the instruction request
// channel and the result request channel.
// ----------------------------------------------------------------------------
interface beu_instr_if;
	logic        valid;
	logic        ready;
	logic [3:0]  command;
	logic [4:0]  dest_reg;
	logic [4:0]  source_reg;
	logic [15:0] imm_value;

	modport source (output valid, command, dest_reg, source_reg, imm_value, input ready);
	modport sink (input valid, command, dest_reg, source_reg, imm_value, output ready);
endinterface

interface beu_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] next_pointer;
	logic        halted;
	logic [63:0] dest_after;
	logic        access_fault;

	modport source (output valid, next_pointer, halted, dest_after, access_fault, input ready);
	modport sink (input valid, next_pointer, halted, dest_after, access_fault, output ready);
endinterface

// ----- hdl/bytecode_execute_unit.sv -----
// ----------------------------------------------------------------------------
// bytecode_execute_unit
// Executes one decoded instruction per request against a 32 x 64-bit
// register file and a byte-addressed data memory.
//
//   channel | direction | payload
//   instr   | sink      | command, dest_reg, source_reg, imm_value
//   result  | source    | next_pointer, halted, dest_after, access_fault
//
// Each instruction passes through accept with register file read, execute
// with data memory access, then write-back with the pointer advance.
// After reset a clearing pass holds instr.ready low until the memory is zeroed.
// A result waits in the output register; a stalled result holds the next
// instruction in write-back.
// ----------------------------------------------------------------------------
module bytecode_execute_unit
	import beu_pkg::*;
#(
	parameter int MEM_BYTES = 65536
) (
	input  logic  clk,
	input  logic  arst_n,
	beu_instr_if.sink    instr,
	beu_result_if.source result
);

	localparam int ROW_W  = $clog2((MEM_BYTES + 7) / 8);
	localparam int ADDR_W = ROW_W + 3;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_WB   = 2'd2;

	logic [1:0]  state_q;
	logic [63:0] ip_q;
	logic        clearing;
	logic        accept;
	logic        finish;

	// Instruction fields, stage one.
	logic [3:0]  cmd_s1;
	logic [4:0]  d_s1;
	logic [15:0] imm_s1;

	// Execute results, stage two.
	logic        is_ld_s2;
	logic        wr_d_s2;
	logic        fault_s2;
	logic        d_is_ip_s2;
	logic [4:0]  d_s2;
	logic [63:0] res_s2;
	logic [63:0] ip_alt_s2;

	// Output register.
	logic        out_valid_q;
	logic [63:0] next_pointer_q;
	logic        halted_q;
	logic [63:0] dest_after_q;
	logic        access_fault_q;

	rf_ctl_t     rf_ctl;
	dm_ctl_t     dm_ctl;
	logic [63:0] rd_d;
	logic [63:0] rd_s;
	logic [63:0] dm_rdata;

	logic [63:0] imm64;
	logic [63:0] sext;
	logic [63:0] opnd;
	logic [63:0] base;
	logic [63:0] addr;
	logic        addr_ok;
	logic        ex_is_ld;
	logic        ex_wr_d;
	logic        ex_fault;
	logic [63:0] ex_res;
	logic [63:0] ex_ip_alt;

	logic [63:0] res_w;
	logic [63:0] ip_new;

	assign accept      = instr.valid && instr.ready;
	assign instr.ready = (state_q == S_IDLE) && !clearing;
	assign finish      = (state_q == S_WB) && (!out_valid_q || result.ready);

	// Register file: read at accept, written at write-back.
	assign rf_ctl.rd = accept;
	assign rf_ctl.wr = finish && wr_d_s2 && !d_is_ip_s2;

	beu_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (rf_ctl),
		.rd_addr_a (instr.dest_reg),
		.rd_addr_b (instr.source_reg),
		.wr_addr   (d_s2),
		.wr_data   (res_w),
		.ip        (ip_q),
		.rdata_a   (rd_d),
		.rdata_b   (rd_s)
	);

	// Operand, address and result of the execute stage.
	always_comb begin
		imm64     = {48'd0, imm_s1};
		sext      = {{48{imm_s1[15]}}, imm_s1};
		opnd      = (imm_s1 != 16'd0) ? imm64 : rd_s;
		base      = (cmd_s1 == OP_STR) ? rd_d : rd_s;
		addr      = base + sext;
		addr_ok   = addr < 64'(MEM_BYTES - 8);
		ex_is_ld  = 1'b0;
		ex_wr_d   = 1'b0;
		ex_fault  = 1'b0;
		ex_res    = rd_d;
		ex_ip_alt = ip_q;
		unique case (cmd_s1)
			OP_MOV: begin
				ex_wr_d = 1'b1;
				ex_res  = opnd;
			end
			OP_SL: begin
				ex_wr_d = 1'b1;
				ex_res  = (|opnd[63:6]) ? 64'd0 : (rd_d << opnd[5:0]);
			end
			OP_SR: begin
				ex_wr_d = 1'b1;
				ex_res  = (|opnd[63:6]) ? 64'd0 : (rd_d >> opnd[5:0]);
			end
			OP_LDR: begin
				ex_wr_d  = 1'b1;
				ex_is_ld = 1'b1;
				ex_fault = !addr_ok;
			end
			OP_STR: begin
				ex_fault = !addr_ok;
			end
			OP_ADD: begin
				ex_wr_d = 1'b1;
				ex_res  = rd_d + opnd;
			end
			OP_SUB: begin
				ex_wr_d = 1'b1;
				ex_res  = rd_d - opnd;
			end
			OP_JZ: begin
				if (rd_s == 64'd0) begin
					ex_ip_alt = sext + rd_d;
				end
			end
			OP_DOWN: begin
				ex_ip_alt = 64'(MEM_BYTES);
			end
			default: begin
			end
		endcase
	end

	// Data memory: accessed in the execute stage when the address is in range.
	assign dm_ctl.rd = (state_q == S_EXEC) && (cmd_s1 == OP_LDR) && addr_ok;
	assign dm_ctl.wr = (state_q == S_EXEC) && (cmd_s1 == OP_STR) && addr_ok;

	beu_datamem #(
		.MEM_BYTES (MEM_BYTES)
	) u_datamem (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (dm_ctl),
		.addr     (addr[ADDR_W-1:0]),
		.wdata    (rd_s),
		.rdata    (dm_rdata),
		.clearing (clearing)
	);

	// Write-back value and pointer advance.
	assign res_w  = is_ld_s2 ? (fault_s2 ? '1 : dm_rdata) : res_s2;
	assign ip_new = ((wr_d_s2 && d_is_ip_s2) ? res_w : ip_alt_s2) + INSTR_BYTES;

	// Pipeline payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= instr.command;
			d_s1   <= instr.dest_reg;
			imm_s1 <= instr.imm_value;
		end
		if (state_q == S_EXEC) begin
			is_ld_s2   <= ex_is_ld;
			wr_d_s2    <= ex_wr_d;
			fault_s2   <= ex_fault;
			d_s2       <= d_s1;
			d_is_ip_s2 <= (d_s1 == IP_INDEX);
			res_s2     <= ex_res;
			ip_alt_s2  <= ex_ip_alt;
		end
		if (finish) begin
			next_pointer_q <= ip_new;
			halted_q       <= ip_new >= 64'(MEM_BYTES);
			dest_after_q   <= d_is_ip_s2 ? ip_new : res_w;
			access_fault_q <= fault_s2;
		end
	end

	// Sequencer, pointer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ip_q        <= 64'd0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_WB;
				end
				S_WB: begin
					if (finish) begin
						state_q <= S_IDLE;
						ip_q    <= ip_new;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.next_pointer = next_pointer_q;
	assign result.halted       = halted_q;
	assign result.dest_after   = dest_after_q;
	assign result.access_fault = access_fault_q;

`ifndef NO_ASSERTIONS
	// No request is taken while the data memory is being cleared.
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		instr.ready |-> !clearing)
		else $error("request accepted during clearing pass");

	// An accepted request moves straight into execute.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_EXEC)
		else $error("accepted request did not enter execute");

	// A result appears only out of write-back.
	a_result_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_WB))
		else $error("result raised outside write-back");

	// Memory is never read and written in the same cycle.
	a_dm_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(dm_ctl.rd && dm_ctl.wr))
		else $error("data memory read and write together");
`endif

endmodule

// ----- hdl/beu_regfile.sv -----
// ----------------------------------------------------------------------------
// beu_regfile
// 32 x 64-bit register file in a synchronous memory with two read ports and
// one write port. Valid bits make unwritten entries read as zero after reset;
// the instruction pointer entry is served from the pointer register instead.
// ----------------------------------------------------------------------------
module beu_regfile
	import beu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  rf_ctl_t     ctl,
	input  logic [4:0]  rd_addr_a,
	input  logic [4:0]  rd_addr_b,
	input  logic [4:0]  wr_addr,
	input  logic [63:0] wr_data,
	input  logic [63:0] ip,
	output logic [63:0] rdata_a,
	output logic [63:0] rdata_b
);

	logic [63:0] rf_mem [32];
	logic [31:0] valid_q;
	logic [63:0] rda_q;
	logic [63:0] rdb_q;
	logic        va_q;
	logic        vb_q;
	logic        ipa_q;
	logic        ipb_q;

	// Memory array: one write and two registered reads per cycle.
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			rf_mem[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			rda_q <= rf_mem[rd_addr_a];
			rdb_q <= rf_mem[rd_addr_b];
		end
	end

	// Valid bits clear at reset and mark written entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			va_q    <= 1'b0;
			vb_q    <= 1'b0;
			ipa_q   <= 1'b0;
			ipb_q   <= 1'b0;
		end else begin
			if (ctl.wr) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd) begin
				va_q  <= valid_q[rd_addr_a];
				vb_q  <= valid_q[rd_addr_b];
				ipa_q <= (rd_addr_a == IP_INDEX);
				ipb_q <= (rd_addr_b == IP_INDEX);
			end
		end
	end

	// Read data selection: pointer, stored value or reset value.
	assign rdata_a = ipa_q ? ip : (va_q ? rda_q : 64'd0);
	assign rdata_b = ipb_q ? ip : (vb_q ? rdb_q : 64'd0);

endmodule

// ----- hdl/beu_datamem.sv -----
// ----------------------------------------------------------------------------
// beu_datamem
// Byte-addressed data memory as eight byte-wide banks, so that one 8-byte
// little-endian access at any byte address is served by all banks together. A
// clearing pass after reset zeroes one row of all banks per cycle.
// ----------------------------------------------------------------------------
module beu_datamem
	import beu_pkg::*;
#(
	parameter int MEM_BYTES = 65536
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  dm_ctl_t                                ctl,
	input  logic [$clog2((MEM_BYTES+7)/8)+2:0]     addr,
	input  logic [63:0]                            wdata,
	output logic [63:0]                            rdata,
	output logic                                   clearing
);

	localparam int ROWS  = (MEM_BYTES + 7) / 8;
	localparam int ROW_W = $clog2(ROWS);

	logic [ROW_W-1:0] base_row;
	logic [2:0]       lo;
	logic [2:0]       lo_q;
	logic [ROW_W-1:0] clr_q;
	logic             clearing_q;
	logic [7:0]       wbyte [8];
	logic [ROW_W-1:0] row   [8];
	logic [7:0]       rbyte_q [8];

	assign base_row = addr[ROW_W+2:3];
	assign lo       = addr[2:0];
	assign clearing = clearing_q;

	// Bank k holds byte (k - lo) mod 8 of the word; banks below lo wrap to the next row.
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			wbyte[k] = wdata[8*3'(3'(k) - lo) +: 8];
			row[k]   = base_row + ROW_W'(3'(k) < lo);
		end
	end

	// Bank memories.
	for (genvar k = 0; k < 8; k++) begin : g_bank
		logic [7:0] bank_mem [ROWS];

		always_ff @(posedge clk) begin
			if (clearing_q) begin
				bank_mem[clr_q] <= 8'd0;
			end else if (ctl.wr) begin
				bank_mem[row[k]] <= wbyte[k];
			end
			if (ctl.rd) begin
				rbyte_q[k] <= bank_mem[row[k]];
			end
		end
	end

	// Rotation offset of the pending read.
	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			lo_q <= lo;
		end
	end

	// Read word assembly: byte j comes from bank (lo + j) mod 8.
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			rdata[8*j +: 8] = rbyte_q[3'(j) + lo_q];
		end
	end

	// Clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == ROW_W'(ROWS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

endmodule
